// ===== sv/rpcfd_pkg.sv =====
// rpcfd_pkg: shared types and constants for the rpc frame deframer
// used by rpcfd_parse and rpc_frame_deframer, no dependencies
package rpcfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KIND_W   = 4;
    // signed room for package length minus three string lengths
    localparam int unsigned BUDGET_W = 36;
    // fixed header bytes outside the strings and payload: 2 + 24
    localparam logic [BUDGET_W-1:0] HDR_OVERHEAD = BUDGET_W'(26);

    localparam logic [BYTE_W-1:0] START_FLAG_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_FLAG_RST   = 8'd3;

    typedef enum logic [0:0] {
        REG_START_FLAG = 1'b0,
        REG_END_FLAG   = 1'b1
    } t_reg_idx;

    typedef enum logic [11:0] {
        PH_SEARCH  = 12'b0000_0000_0001,
        PH_PKGLEN  = 12'b0000_0000_0010,
        PH_IDLEN   = 12'b0000_0000_0100,
        PH_ID      = 12'b0000_0000_1000,
        PH_METHLEN = 12'b0000_0001_0000,
        PH_METH    = 12'b0000_0010_0000,
        PH_ERRCODE = 12'b0000_0100_0000,
        PH_ERRLEN  = 12'b0000_1000_0000,
        PH_ERRMSG  = 12'b0001_0000_0000,
        PH_PAYLOAD = 12'b0010_0000_0000,
        PH_CKSUM   = 12'b0100_0000_0000,
        PH_END     = 12'b1000_0000_0000
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_PKGLEN  = 4'd0,
        K_ID      = 4'd1,
        K_METHOD  = 4'd2,
        K_ERRCODE = 4'd3,
        K_ERRMSG  = 4'd4,
        K_PAYLOAD = 4'd5,
        K_CKSUM   = 4'd6,
        K_DONE    = 4'd7,
        K_DROPPED = 4'd8
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [WORD_W-1:0] value;
        logic              last;
        logic              bad;
    } t_result;

endpackage

// ===== sv/rpcfd_parse.sv =====
// rpcfd_parse: frame parsing state and the per-beat next-state logic
// depends on rpcfd_pkg; result is combinational, registered by the top level
module rpcfd_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [rpcfd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [rpcfd_pkg::BYTE_W-1:0] i_start_flag,
    input  logic [rpcfd_pkg::BYTE_W-1:0] i_end_flag,
    output rpcfd_pkg::t_result           o_result
);
    import rpcfd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_cnt, n_cnt;
    logic [23:0]         r_word, n_word;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic [WORD_W-1:0]   r_rem, n_rem;
    logic                r_len_err, n_len_err;

    logic [WORD_W-1:0]   w;
    logic                word_done;
    logic [BUDGET_W-1:0] budget_less_w;
    logic [BUDGET_W-1:0] pay_src;
    logic [WORD_W-1:0]   pay_rem;
    logic                pay_neg;
    t_phase              pay_phase;
    logic                last_byte;
    t_kind               body_kind;

    assign w             = {r_word, i_data_byte};
    assign word_done     = (r_cnt == 2'd3);
    assign budget_less_w = r_budget - {{(BUDGET_W-WORD_W){1'b0}}, w};
    assign last_byte     = (r_rem == WORD_W'(1));

    // payload length, from the error-length word or after the last message byte
    assign pay_src   = (r_phase == PH_ERRLEN) ? budget_less_w : r_budget;
    assign pay_neg   = pay_src[BUDGET_W-1];
    assign pay_rem   = pay_neg ? '0 : pay_src[WORD_W-1:0];
    assign pay_phase = (pay_rem != '0) ? PH_PAYLOAD : PH_CKSUM;

    always_comb begin
        unique case (r_phase)
            PH_ID:   body_kind = K_ID;
            PH_METH: body_kind = K_METHOD;
            PH_ERRMSG: body_kind = K_ERRMSG;
            default: body_kind = K_PAYLOAD;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_budget  = r_budget;
        n_rem     = r_rem;
        n_len_err = r_len_err;
        o_result  = '{valid: 1'b0, kind: K_PKGLEN, value: '0, last: 1'b0, bad: 1'b0};

        unique case (r_phase)
            PH_PKGLEN, PH_IDLEN, PH_METHLEN, PH_ERRCODE, PH_ERRLEN, PH_CKSUM: begin
                if (!word_done) begin
                    n_cnt  = r_cnt + 2'd1;
                    n_word = w[23:0];
                end else begin
                    n_cnt  = '0;
                    n_word = '0;
                    unique case (r_phase)
                        PH_PKGLEN: begin
                            n_budget = {{(BUDGET_W-WORD_W){1'b0}}, w} - HDR_OVERHEAD;
                            n_phase  = PH_IDLEN;
                            o_result = '{valid: 1'b1, kind: K_PKGLEN, value: w,
                                         last: 1'b0, bad: 1'b0};
                        end
                        PH_IDLEN: begin
                            n_budget = budget_less_w;
                            n_rem    = w;
                            n_phase  = (w != '0) ? PH_ID : PH_METHLEN;
                        end
                        PH_METHLEN: begin
                            n_budget = budget_less_w;
                            n_rem    = w;
                            n_phase  = (w != '0) ? PH_METH : PH_ERRCODE;
                        end
                        PH_ERRCODE: begin
                            n_phase  = PH_ERRLEN;
                            o_result = '{valid: 1'b1, kind: K_ERRCODE, value: w,
                                         last: 1'b0, bad: 1'b0};
                        end
                        PH_ERRLEN: begin
                            n_budget = budget_less_w;
                            if (w != '0) begin
                                n_rem   = w;
                                n_phase = PH_ERRMSG;
                            end else begin
                                n_rem   = pay_rem;
                                n_phase = pay_phase;
                                if (pay_neg) begin
                                    n_len_err = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase  = PH_END;
                            o_result = '{valid: 1'b1, kind: K_CKSUM, value: w,
                                         last: 1'b0, bad: 1'b0};
                        end
                    endcase
                end
            end
            PH_ID, PH_METH, PH_ERRMSG, PH_PAYLOAD: begin
                n_rem    = r_rem - WORD_W'(1);
                o_result = '{valid: 1'b1, kind: body_kind,
                             value: {{(WORD_W-BYTE_W){1'b0}}, i_data_byte},
                             last: last_byte, bad: 1'b0};
                if (last_byte) begin
                    unique case (r_phase)
                        PH_ID:   n_phase = PH_METHLEN;
                        PH_METH: n_phase = PH_ERRCODE;
                        PH_ERRMSG: begin
                            n_rem   = pay_rem;
                            n_phase = pay_phase;
                            if (pay_neg) begin
                                n_len_err = 1'b1;
                            end
                        end
                        default: n_phase = PH_CKSUM;
                    endcase
                end
            end
            PH_END: begin
                n_phase  = PH_SEARCH;
                o_result = '{valid: 1'b1,
                             kind: (i_data_byte == i_end_flag) ? K_DONE : K_DROPPED,
                             value: '0, last: 1'b0, bad: r_len_err};
            end
            default: begin
                // hunting, also taken by any stray phase code
                if (i_data_byte == i_start_flag) begin
                    n_phase   = PH_PKGLEN;
                    n_cnt     = '0;
                    n_word    = '0;
                    n_budget  = '0;
                    n_rem     = '0;
                    n_len_err = 1'b0;
                end else begin
                    n_phase = PH_SEARCH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_cnt     <= '0;
            r_word    <= '0;
            r_budget  <= '0;
            r_rem     <= '0;
            r_len_err <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_word    <= n_word;
            r_budget  <= n_budget;
            r_rem     <= n_rem;
            r_len_err <= n_len_err;
        end
    end

endmodule

// ===== sv/rpc_frame_deframer.sv =====
// rpc_frame_deframer: top level, flag registers and the result register
// depends on rpcfd_pkg and rpcfd_parse
//
// Usage: bytes of the stream enter on the input channel (i_in_valid,
// o_in_stall, i_data_byte), one beat per byte. The block hunts for the start
// flag, then walks the frame: package length, message id, method name, error
// code, error message, payload, checksum and end flag. Each byte yields zero
// or one result beat on the output channel (o_out_valid, i_out_stall): word
// fields come out whole, string and payload bytes one per beat, and the end
// byte gives done or dropped. A byte is accepted every cycle while o_in_stall
// is low; its result, if any, is registered at the accepting edge. The result
// register is the only buffer: while a result waits under i_out_stall,
// o_in_stall is high, and a byte is taken in the same cycle the waiting result
// is taken. Reset is synchronous and clears the parser to hunting and the flags
// to 2 (start) and 3 (end). Flags are written through i_cfg_we / i_cfg_index /
// i_cfg_data, by the user only while the block is idle; the block does not enforce it.
module rpc_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rpcfd_pkg::BYTE_W-1:0] i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rpcfd_pkg::KIND_W-1:0] o_kind,
    output logic [rpcfd_pkg::WORD_W-1:0] o_value,
    output logic                         o_last_in_section,
    output logic                         o_bad_length,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_index,
    input  logic [rpcfd_pkg::BYTE_W-1:0] i_cfg_data
);
    import rpcfd_pkg::*;

    logic [BYTE_W-1:0] r_start_flag;
    logic [BYTE_W-1:0] r_end_flag;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [WORD_W-1:0] r_value;
    logic              r_last;
    logic              r_bad;

    logic    in_accept;
    logic    out_free;
    t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_accept  = i_in_valid && out_free;

    rpcfd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_start_flag (r_start_flag),
        .i_end_flag   (r_end_flag),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag <= START_FLAG_RST;
            r_end_flag   <= END_FLAG_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_START_FLAG: r_start_flag <= i_cfg_data;
                REG_END_FLAG:   r_end_flag   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_accept && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_accept && result.valid) begin
            r_kind  <= result.kind;
            r_value <= result.value;
            r_last  <= result.last;
            r_bad   <= result.bad;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_value           = r_value;
    assign o_last_in_section = r_last;
    assign o_bad_length      = r_bad;

endmodule

// ===== tb/rpc_frame_deframer_test.sv =====
// rpc_frame_deframer_test: self-checking bench for the rpc frame deframer, with its own
// frame generator, a byte-level predictor of the parser and a beat-by-beat result check
// depends on rpcfd_pkg and rpc_frame_deframer
module rpc_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcfd_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    typedef enum int { END_GOOD, END_AS_START, END_OTHER } t_closing;

    typedef struct {
        t_kind             kind;
        logic [WORD_W-1:0] value;
        logic              last;
        logic              bad;
    } t_frame_beat;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we = 1'b0;
    t_reg_idx          cfg_index = REG_START_FLAG;
    logic [BYTE_W-1:0] cfg_data = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [KIND_W-1:0] o_kind;
    logic [WORD_W-1:0] o_value;
    logic              o_last_in_section;
    logic              o_bad_length;

    rpc_frame_deframer i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_kind            (o_kind),
        .o_value           (o_value),
        .o_last_in_section (o_last_in_section),
        .o_bad_length      (o_bad_length),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // flag copies and parser state of the predictor
    logic [BYTE_W-1:0] start_flag_q = START_FLAG_RST;
    logic [BYTE_W-1:0] end_flag_q   = END_FLAG_RST;
    t_phase            ph           = PH_SEARCH;
    logic [1:0]        wcnt         = '0;
    logic [WORD_W-1:0] wacc         = '0;
    logic [WORD_W-1:0] pkg_len      = '0;
    logic [33:0]       str_sum      = '0;
    logic [WORD_W-1:0] remain       = '0;
    logic              len_err      = 1'b0;

    logic [BYTE_W-1:0] stream_bytes[$];
    t_frame_beat       expected_beats[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int bytes_taken   = 0;
    int beats_checked = 0;
    int frames_done   = 0;
    int frames_dropped = 0;
    int frames_clamped = 0;

    function automatic void append_byte(logic [BYTE_W-1:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic void add_beat(t_kind kind, logic [WORD_W-1:0] value, logic last,
                                     logic bad);
        t_frame_beat fb;
        fb.kind  = kind;
        fb.value = value;
        fb.last  = last;
        fb.bad   = bad;
        expected_beats.insert(expected_beats.size(), fb);
    endfunction

    function automatic void open_payload();
        longint p;
        p = longint'(pkg_len) - longint'(str_sum) - 26;
        if (p < 0) begin
            len_err = 1'b1;
            p = 0;
        end
        remain = p[WORD_W-1:0];
        ph = (remain != 0) ? PH_PAYLOAD : PH_CKSUM;
    endfunction

    function automatic void open_string(logic [WORD_W-1:0] len, t_phase body, t_phase skip);
        str_sum += len;
        remain = len;
        ph = (len != 0) ? body : skip;
    endfunction

    // one received byte through the parser, expected beat queued if it makes one
    function automatic void deframe_byte(logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] w;
        t_kind             sk;
        logic              last;
        case (ph)
            PH_PKGLEN, PH_IDLEN, PH_METHLEN, PH_ERRCODE, PH_ERRLEN, PH_CKSUM: begin
                wacc = {wacc[23:0], b};
                if (wcnt != 2'd3) begin
                    wcnt++;
                end else begin
                    wcnt = '0;
                    w = wacc;
                    wacc = '0;
                    case (ph)
                        PH_PKGLEN: begin
                            pkg_len = w;
                            ph = PH_IDLEN;
                            add_beat(K_PKGLEN, w, 1'b0, 1'b0);
                        end
                        PH_IDLEN:   open_string(w, PH_ID, PH_METHLEN);
                        PH_METHLEN: open_string(w, PH_METH, PH_ERRCODE);
                        PH_ERRCODE: begin
                            ph = PH_ERRLEN;
                            add_beat(K_ERRCODE, w, 1'b0, 1'b0);
                        end
                        PH_ERRLEN: begin
                            str_sum += w;
                            remain = w;
                            if (w != 0) ph = PH_ERRMSG;
                            else open_payload();
                        end
                        default: begin
                            ph = PH_END;
                            add_beat(K_CKSUM, w, 1'b0, 1'b0);
                        end
                    endcase
                end
            end
            PH_ID, PH_METH, PH_ERRMSG, PH_PAYLOAD: begin
                case (ph)
                    PH_ID:     sk = K_ID;
                    PH_METH:   sk = K_METHOD;
                    PH_ERRMSG: sk = K_ERRMSG;
                    default:   sk = K_PAYLOAD;
                endcase
                remain--;
                last = (remain == 0);
                if (last) begin
                    case (ph)
                        PH_ID:     ph = PH_METHLEN;
                        PH_METH:   ph = PH_ERRCODE;
                        PH_ERRMSG: open_payload();
                        default:   ph = PH_CKSUM;
                    endcase
                end
                add_beat(sk, WORD_W'(b), last, 1'b0);
            end
            PH_END: begin
                ph = PH_SEARCH;
                if (b == end_flag_q) add_beat(K_DONE, '0, 1'b0, len_err);
                else add_beat(K_DROPPED, '0, 1'b0, len_err);
            end
            default: begin
                if (b == start_flag_q) begin
                    ph = PH_PKGLEN;
                    wcnt = '0;
                    wacc = '0;
                    pkg_len = '0;
                    str_sum = '0;
                    remain = '0;
                    len_err = 1'b0;
                end else begin
                    ph = PH_SEARCH;
                end
            end
        endcase
    endfunction

    // sender: holds a byte until taken, gaps drawn per slot
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                deframe_byte(in_byte);
                bytes_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_byte  <= stream_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_frame_beat fb;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                beats_checked++;
                if (o_kind == K_DONE) frames_done++;
                if (o_kind == K_DROPPED) frames_dropped++;
                if (o_bad_length) frames_clamped++;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat kind %0d value %h last %b bad %b", $time,
                             o_kind, o_value, o_last_in_section, o_bad_length);
                end else begin
                    fb = expected_beats.pop_front();
                    if (o_kind != fb.kind) begin
                        mismatches++;
                        $display("%0t: kind expected %0d actual %0d", $time, fb.kind, o_kind);
                    end
                    if (o_value != fb.value) begin
                        mismatches++;
                        $display("%0t: value expected %h actual %h", $time, fb.value, o_value);
                    end
                    if (o_last_in_section != fb.last) begin
                        mismatches++;
                        $display("%0t: last_in_section expected %b actual %b", $time, fb.last,
                                 o_last_in_section);
                    end
                    if (o_bad_length != fb.bad) begin
                        mismatches++;
                        $display("%0t: bad_length expected %b actual %b", $time, fb.bad,
                                 o_bad_length);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // no beat on either side for too long means the block is stuck
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress, %0d beats still expected", $time,
                     expected_beats.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] byte_other_than(logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom_range(0, 255));
        if (r == v) r = r + 1'b1;
        return r;
    endfunction

    function automatic void queue_word(logic [WORD_W-1:0] w);
        append_byte(w[31:24]);
        append_byte(w[23:16]);
        append_byte(w[15:8]);
        append_byte(w[7:0]);
    endfunction

    function automatic void queue_text(int n);
        for (int k = 0; k < n; k++) append_byte(BYTE_W'($urandom_range(0, 255)));
    endfunction

    // bytes that never open a frame
    function automatic void queue_noise(int n);
        for (int k = 0; k < n; k++) append_byte(byte_other_than(start_flag_q));
    endfunction

    function automatic void queue_frame(int id_n, int meth_n, int err_n,
                                        logic [WORD_W-1:0] pkg, t_closing closing,
                                        logic [WORD_W-1:0] code, logic [WORD_W-1:0] cksum);
        longint pay;
        pay = longint'(pkg) - id_n - meth_n - err_n - 26;
        if (pay < 0) pay = 0;
        append_byte(start_flag_q);
        queue_word(pkg);
        queue_word(WORD_W'(id_n));
        queue_text(id_n);
        queue_word(WORD_W'(meth_n));
        queue_text(meth_n);
        queue_word(code);
        queue_word(WORD_W'(err_n));
        queue_text(err_n);
        queue_text(int'(pay));
        queue_word(cksum);
        if (closing == END_GOOD) append_byte(end_flag_q);
        else if (closing == END_AS_START && start_flag_q != end_flag_q)
            append_byte(start_flag_q);
        else append_byte(byte_other_than(end_flag_q));
    endfunction

    // mostly well-formed frames, some clamped lengths, bad closings and noise
    function automatic void queue_traffic(int n_bytes);
        int       id_n, meth_n, err_n, sum, r, target;
        t_closing closing;
        logic [WORD_W-1:0] pkg;
        target = stream_bytes.size() + n_bytes;
        while (stream_bytes.size() < target) begin
            id_n   = $urandom_range(0, 4);
            meth_n = $urandom_range(0, 6);
            err_n  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            sum    = id_n + meth_n + err_n;
            if ($urandom_range(0, 6) == 0) pkg = $urandom_range(0, sum + 25);
            else pkg = sum + 26 + $urandom_range(0, 8);
            r = $urandom_range(0, 9);
            closing = (r < 7) ? END_GOOD : (r == 7) ? END_AS_START : END_OTHER;
            if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 3));
            queue_frame(id_n, meth_n, err_n, pkg, closing, $urandom, $urandom);
        end
    endfunction

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
        // last byte may have been a length byte with nothing to show
        repeat (4) @(posedge clk);
    endtask

    task automatic write_flags(logic [BYTE_W-1:0] sflag, logic [BYTE_W-1:0] eflag);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_FLAG;
        cfg_data  <= sflag;
        @(posedge clk);
        cfg_index <= REG_END_FLAG;
        cfg_data  <= eflag;
        @(posedge clk);
        cfg_we <= 1'b0;
        start_flag_q = sflag;
        end_flag_q   = eflag;
    endtask

    task automatic run_phase(logic [BYTE_W-1:0] sflag, logic [BYTE_W-1:0] eflag, int idle,
                             int stall, int n_bytes);
        write_flags(sflag, eflag);
        send_idle_pct = idle;
        stall_pct     = stall;
        @(negedge clk);
        queue_traffic(n_bytes);
        wait_drained();
    endtask

    initial begin
        logic [BYTE_W-1:0] same_flag;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed frames on the reset flags
        queue_noise(2);
        queue_frame(0, 0, 0, 32'd26, END_GOOD, 32'h0000_0000, 32'h0000_0000);
        queue_frame(0, 0, 0, 32'd0, END_GOOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_frame(1, 1, 1, 32'd30, END_AS_START, 32'h8000_0001, 32'h7FFF_FFFE);
        queue_noise(1);
        // clamp reached from the error message path, then a drop
        queue_frame(2, 0, 3, 32'd10, END_OTHER, 32'h1234_5678, 32'h55AA_AA55);
        queue_frame(3, 2, 0, 32'd33, END_GOOD, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
        queue_frame(0, 4, 2, 32'd40, END_GOOD, 32'h0000_00FF, 32'hFF00_0000);
        wait_drained();
        write_flags(START_FLAG_RST, END_FLAG_RST);
        queue_traffic(40);
        wait_drained();

        same_flag = BYTE_W'($urandom_range(0, 255));
        run_phase(8'h00, 8'hFF, 0, 0, 60);
        run_phase(8'hFF, 8'h00, 50, 0, 60);
        run_phase(same_flag, same_flag, 0, 50, 60);
        run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 25, 25,
                  60);

        $display("%0d bytes sent, %0d result beats checked", bytes_taken, beats_checked);
        $display("frames: %0d done, %0d dropped, %0d with clamped length", frames_done,
                 frames_dropped, frames_clamped);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
